[src/pmtu_pkg.sv]
// Package for the path MTU cache: payload structs, constants, controller/datapath interface.
// No dependencies.
`timescale 1ns / 1ps
package pmtu_pkg;

	localparam int ENTRIES_DEF = 16;
	localparam logic [31:0] PROBE_INTERVAL_RST = 32'd600000;
	localparam logic [16:0] MIN_LINK_MTU = 17'd1280;
	localparam logic [47:0] MAX_TIME = 48'hFFFF_FFFF_FFFF;

	localparam logic [2:0] KIND_ESTIMATE = 3'd0;
	localparam logic [2:0] KIND_BEGIN = 3'd1;
	localparam logic [2:0] KIND_CONFIRM = 3'd2;
	localparam logic [2:0] KIND_UPDATE = 3'd3;
	localparam logic [2:0] KIND_REMOVE = 3'd4;
	localparam logic [2:0] KIND_CLEAR = 3'd5;

	localparam logic [1:0] ST_INVALID = 2'd0;
	localparam logic [1:0] ST_UNCHANGED = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_DECREASED = 2'd3;

	typedef struct packed {
		logic [2:0] kind;
		logic [63:0] dest_hi;
		logic [63:0] dest_lo;
		logic [31:0] iface;
		logic [16:0] hop_mtu;
		logic [16:0] packet_size;
		logic [16:0] ptb_mtu;
		logic [47:0] timestamp;
	} pmtu_in_t;

	typedef struct packed {
		logic [16:0] mtu_out;
		logic [1:0] update_status;
		logic confirmed;
		logic [4:0] entry_count;
	} pmtu_out_t;

	// Controller to datapath
	typedef struct packed {
		logic load;     // capture the input transaction
		logic scan_rst; // restart slot pointer
		logic scan;     // examine the current slot and advance
		logic finish;   // apply the decision and form the result
		logic retime;   // register the retry time sum
	} pmtu_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic scan_last;
	} pmtu_sts_t;

endpackage

[src/pmtu_ctrl.sv]
// Controller for the path MTU cache: sequences load, slot scan, write-back and result.
// Depends on pmtu_pkg.
`timescale 1ns / 1ps
module pmtu_ctrl import pmtu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  pmtu_sts_t sts,
	output pmtu_cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_TIME = 3'd2;
	localparam logic [2:0] S_DONE = 3'd3;
	localparam logic [2:0] S_OUT = 3'd4;

	logic [2:0] state_q;

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);

	// Decode commands from state
	always_comb begin
		cmd = '0;
		cmd.load = (state_q == S_IDLE) && in_valid;
		cmd.scan_rst = cmd.load;
		cmd.scan = (state_q == S_SCAN);
		cmd.retime = (state_q == S_TIME);
		cmd.finish = (state_q == S_DONE);
	end

	// Advance the sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_SCAN;
				S_SCAN: if (sts.scan_last) state_q <= S_TIME;
				S_TIME: state_q <= S_DONE;
				S_DONE: state_q <= S_OUT;
				S_OUT: if (!out_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[src/pmtu_dpath.sv]
// Datapath for the path MTU cache: slot storage, serial match scan, update logic, result.
// Depends on pmtu_pkg.
`timescale 1ns / 1ps
module pmtu_dpath import pmtu_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [31:0] cfg_wdata,
	input  pmtu_in_t in_data,
	input  pmtu_cmd_t cmd,
	output pmtu_sts_t sts,
	output pmtu_out_t out_data
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);

	logic [31:0] interval_q;
	pmtu_in_t req_q;
	logic [ENTRIES-1:0] used_q;
	logic [63:0] hi_q [ENTRIES];
	logic [63:0] lo_q [ENTRIES];
	logic [31:0] ifc_q [ENTRIES];
	logic [16:0] mtu_q [ENTRIES];
	logic [16:0] prb_q [ENTRIES];
	logic [47:0] rty_q [ENTRIES];

	logic [IW:0] ptr_q;
	logic hit_q, free_q;
	logic [IW-1:0] hit_idx_q, free_idx_q;
	logic [ENTRIES-1:0] drop_q;
	logic [CW-1:0] count_q;
	logic [47:0] retry_q;
	pmtu_out_t res_q;

	logic [IW-1:0] cur_idx;
	logic key_match;
	assign cur_idx = ptr_q[IW-1:0];
	assign key_match = used_q[cur_idx] && hi_q[cur_idx] == req_q.dest_hi
		&& lo_q[cur_idx] == req_q.dest_lo && ifc_q[cur_idx] == req_q.iface;
	assign sts.scan_last = (ptr_q == (IW+1)'(ENTRIES - 1));
	assign out_data = res_q;

	// Hold the probe interval register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) interval_q <= PROBE_INTERVAL_RST;
		else if (cfg_we) interval_q <= cfg_wdata;
	end

	// Capture the transaction
	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= in_data;
	end

	// Scan slots one per cycle: first hit, first free, interface matches, occupancy
	always_ff @(posedge clk) begin
		if (cmd.scan_rst) begin
			ptr_q <= '0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			hit_idx_q <= '0;
			free_idx_q <= '0;
			drop_q <= '0;
			count_q <= '0;
		end else if (cmd.scan) begin
			ptr_q <= ptr_q + 1'b1;
			if (key_match && !hit_q) begin
				hit_q <= 1'b1;
				hit_idx_q <= cur_idx;
			end
			if (!used_q[cur_idx] && !free_q) begin
				free_q <= 1'b1;
				free_idx_q <= cur_idx;
			end
			drop_q[cur_idx] <= used_q[cur_idx] && ifc_q[cur_idx] == req_q.iface;
			if (used_q[cur_idx]) count_q <= count_q + 1'b1;
		end
	end

	// Register the saturated retry time
	always_ff @(posedge clk) begin
		logic [48:0] sum;
		sum = {1'b0, req_q.timestamp} + 49'(interval_q);
		if (cmd.retime) retry_q <= sum[48] ? MAX_TIME : sum[47:0];
	end

	// Decision logic on the scan result
	logic [16:0] e_mtu, e_prb, cur, cand;
	logic [47:0] e_rty;
	logic bad;
	always_comb begin
		e_mtu = mtu_q[hit_idx_q];
		e_prb = prb_q[hit_idx_q];
		e_rty = rty_q[hit_idx_q];
		cur = (hit_q && e_mtu < req_q.hop_mtu) ? e_mtu : req_q.hop_mtu;
		cand = (req_q.packet_size < req_q.hop_mtu) ? req_q.packet_size
			: req_q.hop_mtu;
		bad = req_q.iface == '0 || (req_q.dest_hi == '0 && req_q.dest_lo == '0)
			|| req_q.ptb_mtu < MIN_LINK_MTU || req_q.hop_mtu < MIN_LINK_MTU;
	end

	// Write back slots and form the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (cmd.finish) begin
			if (req_q.kind == KIND_REMOVE) used_q <= used_q & ~drop_q;
			else if (req_q.kind == KIND_CLEAR) used_q <= '0;
			else if (req_q.kind == KIND_UPDATE && !bad && req_q.ptb_mtu < cur
				&& !hit_q && free_q) used_q[free_idx_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		pmtu_out_t res;
		logic [CW-1:0] cnt;
		if (cmd.finish) begin
			res = '0;
			cnt = count_q;
			case (req_q.kind)
				KIND_ESTIMATE: res.mtu_out = cur;
				KIND_BEGIN: begin
					if (hit_q && !(e_rty > req_q.timestamp) && cand > cur) begin
						prb_q[hit_idx_q] <= cand;
						rty_q[hit_idx_q] <= retry_q;
						res.mtu_out = cand;
					end else begin
						res.mtu_out = cur;
					end
				end
				KIND_CONFIRM: begin
					if (hit_q && e_prb > e_mtu) begin
						mtu_q[hit_idx_q] <= e_prb;
						prb_q[hit_idx_q] <= '0;
						rty_q[hit_idx_q] <= retry_q;
						res.confirmed = 1'b1;
					end
				end
				KIND_UPDATE: begin
					if (bad) begin
						res.update_status = ST_INVALID;
					end else if (req_q.ptb_mtu >= cur) begin
						if (hit_q) begin
							prb_q[hit_idx_q] <= '0;
							rty_q[hit_idx_q] <= retry_q;
						end
						res.update_status = ST_UNCHANGED;
					end else if (hit_q) begin
						mtu_q[hit_idx_q] <= req_q.ptb_mtu;
						prb_q[hit_idx_q] <= '0;
						rty_q[hit_idx_q] <= retry_q;
						res.update_status = ST_DECREASED;
					end else if (free_q) begin
						hi_q[free_idx_q] <= req_q.dest_hi;
						lo_q[free_idx_q] <= req_q.dest_lo;
						ifc_q[free_idx_q] <= req_q.iface;
						mtu_q[free_idx_q] <= req_q.ptb_mtu;
						prb_q[free_idx_q] <= '0;
						rty_q[free_idx_q] <= retry_q;
						cnt = count_q + 1'b1;
						res.update_status = ST_DECREASED;
					end else begin
						res.update_status = ST_FULL;
					end
				end
				KIND_REMOVE: begin
					cnt = count_q - CW'($countones(drop_q));
					for (int i = 0; i < ENTRIES; i++) begin
						if (drop_q[i]) begin
							hi_q[i] <= '0;
							lo_q[i] <= '0;
							ifc_q[i] <= '0;
							mtu_q[i] <= '0;
							prb_q[i] <= '0;
							rty_q[i] <= '0;
						end
					end
				end
				KIND_CLEAR: begin
					cnt = '0;
					for (int i = 0; i < ENTRIES; i++) begin
						hi_q[i] <= '0;
						lo_q[i] <= '0;
						ifc_q[i] <= '0;
						mtu_q[i] <= '0;
						prb_q[i] <= '0;
						rty_q[i] <= '0;
					end
				end
				default: ;
			endcase
			res.entry_count = 5'(cnt);
			res_q <= res;
		end
	end

endmodule

[src/path_mtu_cache_unit.sv]
// Top level of the path MTU cache: joins the controller and the datapath.
// Depends on pmtu_pkg, pmtu_ctrl, pmtu_dpath.
`timescale 1ns / 1ps
// Path MTU cache for IPv6 destinations keyed by destination and interface. Each
// transaction is handled alone: after acceptance come the serial match scan, one slot
// per cycle, then the retry time add and the write-back into the result register. A
// new transaction is taken the cycle after the result has been accepted. Freed slots
// read as zero; no clearing pass is needed.
module path_mtu_cache_unit import pmtu_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic in_valid,
	output logic in_stall,
	input  pmtu_in_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output pmtu_out_t out_data
);

	pmtu_cmd_t cmd;
	pmtu_sts_t sts;

	pmtu_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
	);

	pmtu_dpath #(.ENTRIES(ENTRIES)) u_dpath (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_data(in_data), .cmd(cmd), .sts(sts), .out_data(out_data)
	);

endmodule
